[hw/rtl/fdsa_pkg.sv]
// Shared types, codes and sizes for the Forth data stack word unit.
package fdsa_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int ADDR_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 4;
   localparam int DEPTH_FIELD_W = 7;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 4'd0,
      CMD_SUB    = 4'd1,
      CMD_MUL    = 4'd2,
      CMD_DIV    = 4'd3,
      CMD_MOD    = 4'd4,
      CMD_PRINT  = 4'd5,
      CMD_EMIT   = 4'd6,
      CMD_DUP    = 4'd7,
      CMD_DROP   = 4'd8,
      CMD_CR     = 4'd9,
      CMD_INDEX  = 4'd10,
      CMD_INVERT = 4'd11,
      CMD_EQUAL  = 4'd12
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRINT   = 2'd1,
      EV_EMIT    = 2'd2,
      EV_NEWLINE = 2'd3
   } event_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic rd_top;
      logic rd_next;
      logic ld_b;
      logic ld_a;
      logic div_start;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic div_needed;
      logic div_busy;
   } dp_stat_type;

endpackage

[hw/rtl/fdsa_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
module fdsa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fdsa_pkg::DATA_W-1:0] dividend,
   input  logic [fdsa_pkg::DATA_W-1:0] divisor,
   output logic                       busy,
   output logic [fdsa_pkg::DATA_W-1:0] quotient,
   output logic [fdsa_pkg::DATA_W-1:0] remainder
);
   import fdsa_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] dvs_ff;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   // A clear top bit of the difference means the divisor fits.
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         step_ff <= STEP_W'(DATA_W - 1);
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/fdsa_datapath.sv]
// Stack memory, operand registers, word evaluation and result registers.
module fdsa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  fdsa_pkg::dp_cmd_type        dp_cmd,
   output fdsa_pkg::dp_stat_type       dp_stat,
   input  fdsa_pkg::cmd_type           req_command,
   input  logic [fdsa_pkg::DATA_W-1:0] req_loop_index,
   output fdsa_pkg::status_type        rsp_status,
   output fdsa_pkg::event_type         rsp_event_kind,
   output logic [fdsa_pkg::DATA_W-1:0] rsp_event_value,
   output logic [fdsa_pkg::DEPTH_FIELD_W-1:0] rsp_stack_depth
);
   import fdsa_pkg::*;

   logic [DATA_W-1:0] mem [STACK_DEPTH];

   cmd_type            cmd_ff;
   logic [DATA_W-1:0]  idx_ff;
   logic [DATA_W-1:0]  a_ff;
   logic [DATA_W-1:0]  b_ff;
   logic [DATA_W-1:0]  rd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   status_type         status_ff;
   status_type         status_in;
   event_type          kind_ff;
   event_type          kind_in;
   logic [DATA_W-1:0]  value_ff;
   logic [DATA_W-1:0]  value_in;
   logic [DEPTH_FIELD_W-1:0] depth_ff;

   logic [1:0]         need;
   logic               under;
   logic               over;
   logic               is_div;
   logic               b_zero;
   logic               ok;
   logic [ADDR_W-1:0]  top_addr;
   logic [ADDR_W-1:0]  next_addr;
   logic [ADDR_W-1:0]  push_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [DATA_W-1:0]  mag_a;
   logic [DATA_W-1:0]  mag_b;
   logic [DATA_W-1:0]  quo;
   logic [DATA_W-1:0]  rem;
   logic [DATA_W-1:0]  quo_s;
   logic [DATA_W-1:0]  rem_s;
   logic [DATA_W-1:0]  mul_lo;
   logic [DATA_W-1:0]  res;

   assign top_addr  = ADDR_W'(count_ff - CNT_W'(1));
   assign next_addr = ADDR_W'(count_ff - CNT_W'(2));
   assign push_addr = ADDR_W'(count_ff);
   assign rd_addr   = dp_cmd.rd_next ? next_addr : top_addr;

   always_comb begin
      case (cmd_ff)
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQUAL: need = 2'd2;
         CMD_PRINT, CMD_EMIT, CMD_DUP, CMD_DROP, CMD_INVERT:     need = 2'd1;
         default:                                                need = 2'd0;
      endcase
   end

   assign under  = count_ff < CNT_W'(need);
   assign over   = (cmd_ff == CMD_DUP || cmd_ff == CMD_INDEX) &&
                   count_ff == CNT_W'(STACK_DEPTH);
   assign is_div = cmd_ff == CMD_DIV || cmd_ff == CMD_MOD;
   assign b_zero = b_ff == '0;
   assign ok     = !under && !over && !(is_div && b_zero);

   assign dp_stat.div_needed = is_div && !under && !b_zero;

   assign mag_a = a_ff[DATA_W-1] ? -a_ff : a_ff;
   assign mag_b = b_ff[DATA_W-1] ? -b_ff : b_ff;

   fdsa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dp_cmd.div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .busy      (dp_stat.div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   // Quotient takes the sign of a xor b, remainder the sign of the dividend.
   assign quo_s  = (a_ff[DATA_W-1] ^ b_ff[DATA_W-1]) ? -quo : quo;
   assign rem_s  = a_ff[DATA_W-1] ? -rem : rem;
   assign mul_lo = a_ff * b_ff;

   always_comb begin
      case (cmd_ff)
         CMD_ADD: res = a_ff + b_ff;
         CMD_SUB: res = a_ff - b_ff;
         CMD_MUL: res = mul_lo;
         CMD_DIV: res = quo_s;
         CMD_MOD: res = rem_s;
         default: res = (a_ff == b_ff) ? '1 : '0;
      endcase
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = next_addr;
      wr_data   = res;
      count_in  = count_ff;
      kind_in   = EV_NONE;
      value_in  = '0;
      if (under) begin
         status_in = ST_UNDER;
      end else if (over) begin
         status_in = ST_OVER;
      end else if (is_div && b_zero) begin
         status_in = ST_DIVZ;
      end else begin
         status_in = ST_OK;
      end
      if (ok) begin
         case (cmd_ff)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQUAL: begin
               wr_en    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
            CMD_PRINT: begin
               kind_in  = EV_PRINT;
               value_in = b_ff;
               count_in = count_ff - CNT_W'(1);
            end
            CMD_EMIT: begin
               kind_in  = EV_EMIT;
               value_in = {{(DATA_W-8){1'b0}}, b_ff[7:0]};
               count_in = count_ff - CNT_W'(1);
            end
            CMD_DUP: begin
               wr_en    = 1'b1;
               wr_addr  = push_addr;
               wr_data  = b_ff;
               count_in = count_ff + CNT_W'(1);
            end
            CMD_DROP: begin
               count_in = count_ff - CNT_W'(1);
            end
            CMD_CR: begin
               kind_in = EV_NEWLINE;
            end
            CMD_INDEX: begin
               wr_en    = 1'b1;
               wr_addr  = push_addr;
               wr_data  = idx_ff;
               count_in = count_ff + CNT_W'(1);
            end
            CMD_INVERT: begin
               wr_en   = 1'b1;
               wr_addr = top_addr;
               wr_data = b_zero ? '1 : '0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.finish) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rd_top || dp_cmd.rd_next) begin
         rd_ff <= mem[rd_addr];
      end
      if (dp_cmd.finish && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_command;
         idx_ff <= req_loop_index;
      end
      if (dp_cmd.ld_b) begin
         b_ff <= rd_ff;
      end
      if (dp_cmd.ld_a) begin
         a_ff <= rd_ff;
      end
      if (dp_cmd.finish) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         value_ff  <= value_in;
         depth_ff  <= DEPTH_FIELD_W'(count_in);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_value = value_ff;
   assign rsp_stack_depth = depth_ff;

endmodule

[hw/rtl/fdsa_ctrl.sv]
// Sequencing state machine and output handshake for the word unit.
module fdsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output fdsa_pkg::dp_cmd_type  dp_cmd,
   input  fdsa_pkg::dp_stat_type dp_stat
);
   import fdsa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_TOP,
      S_RD_NEXT,
      S_LD_A,
      S_CHECK,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      dp_cmd           = '0;
      dp_cmd.load      = state_ff == S_IDLE && req_tvalid;
      dp_cmd.rd_top    = state_ff == S_RD_TOP;
      dp_cmd.rd_next   = state_ff == S_RD_NEXT;
      dp_cmd.ld_b      = state_ff == S_RD_NEXT;
      dp_cmd.ld_a      = state_ff == S_LD_A;
      dp_cmd.div_start = state_ff == S_CHECK && dp_stat.div_needed;
      dp_cmd.finish    = state_ff == S_FINISH && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (dp_cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_RD_TOP;
               end
            end
            S_RD_TOP:  state_ff <= S_RD_NEXT;
            S_RD_NEXT: state_ff <= S_LD_A;
            S_LD_A:    state_ff <= S_CHECK;
            S_CHECK: begin
               state_ff <= dp_stat.div_needed ? S_DIV : S_FINISH;
            end
            S_DIV: begin
               if (!dp_stat.div_busy) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/forth_data_stack_alu.sv]
// Top level of the Forth data stack word unit: controller, datapath and checks.
//
//  Channel  Direction  Payload
//  req_     in         tdata: command [3:0], loop_index [35:4], zero [39:36]
//  rsp_     out        tdata: status [1:0], event_value [33:2], stack_depth [40:34];
//                      tuser: event_kind [1:0]
//
// Each item is taken in the idle state; the top two stack entries are then read from the
// single-port stack memory over the RD_TOP, RD_NEXT and LD_A states and the word is
// checked in the CHECK state. Most words then go straight to FINISH, which places the
// result in the output register. Divide and modulo with valid operands also run the
// 32-step shift-subtract divider in the DIV state first, which makes them the slowest
// words; a new item is taken only once the unit is back in the idle state. Reset clears
// the stack count, the controller and handshake state and the divider's busy flag only;
// the stack memory is not cleared. A stalled result waits in the output register while
// the next item is taken and runs up to its final step, where it waits until the output register is free.
module forth_data_stack_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command [3:0], loop_index [35:4], zero padding [39:36]
   input  logic [fdsa_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status [1:0], event_value [33:2], stack_depth [40:34], zero padding [47:41]
   output logic [fdsa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // event_kind [1:0]
   output logic [1:0]                           rsp_tuser
);
   import fdsa_pkg::*;

   dp_cmd_type                dp_cmd;
   dp_stat_type               dp_stat;
   status_type                status;
   event_type                 event_kind;
   logic [DATA_W-1:0]         event_value;
   logic [DEPTH_FIELD_W-1:0]  stack_depth;

   fdsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat)
   );

   // The datapath latches the item only when the controller says it is taken.
   fdsa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .req_command     (cmd_type'(req_tdata[CMD_W-1:0])),
      .req_loop_index  (req_tdata[CMD_W+DATA_W-1:CMD_W]),
      .rsp_status      (status),
      .rsp_event_kind  (event_kind),
      .rsp_event_value (event_value),
      .rsp_stack_depth (stack_depth)
   );

   assign rsp_tdata = {(RSP_TDATA_W - DEPTH_FIELD_W - DATA_W - 2)'(0),
                       stack_depth, event_value, status};
   assign rsp_tuser = event_kind;

   // Once an item is taken the unit is busy with it for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while the previous one was still in work");

   // A failing word never reports an event.
   a_fail_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status != ST_OK) |-> event_kind == EV_NONE)
      else $error("event reported together with a failure status");

   // An emitted character carries only its low byte.
   a_emit_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && event_kind == EV_EMIT) |-> event_value[DATA_W-1:8] == '0)
      else $error("emit event with upper value bits set");

endmodule

[tb/sv/forth_data_stack_alu_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Forth data stack word unit, with its own stack predictor.
module forth_data_stack_alu_tb;
   import fdsa_pkg::*;

   localparam int CLK_PERIOD       = 4;
   localparam int ITEMS_PER_PHASE  = 330;
   localparam int LONG_HOLD        = 400;
   localparam int SETTLE_CYCLES    = 60;
   localparam int WATCHDOG_CYCLES  = 1_500_000;
   localparam int MAX_FAULT_LINES  = 40;

   // The three codes above the last defined word do nothing; they are still legal input.
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;
   localparam logic [DATA_W-1:0] FORTH_TRUE     = '1;
   localparam logic [DATA_W-1:0] INT_MIN        = 32'h8000_0000;
   localparam logic [DATA_W-1:0] INT_MAX        = 32'h7fff_ffff;

   // One word as it is queued for the driver.
   typedef struct {
      logic [CMD_W-1:0]  code;
      logic [DATA_W-1:0] idx;
   } forth_word_type;

   // What the unit should report for one word.
   typedef struct {
      status_type                 status;
      event_type                  kind;
      logic [DATA_W-1:0]          value;
      logic [DEPTH_FIELD_W-1:0]   depth;
   } word_outcome_type;

   // The random part moves between filling, draining and mixed stretches so that the
   // stack regularly reaches both its empty and its full end.
   typedef enum {PLAN_FILL, PLAN_DRAIN, PLAN_MIX} plan_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic [1:0]                rsp_tuser;

   logic                      req_taken = 1'b0;

   forth_word_type            words_to_send[$];
   word_outcome_type          word_outcomes[$];

   // Shadow copy of the stack, advanced once for every word the unit accepts.
   logic [DATA_W-1:0]         shadow_stack [STACK_DEPTH];
   int                        shadow_depth = 0;

   // Rough depth as seen by the stimulus planner; only used to steer the mix of words.
   int                        planned_depth = 0;
   plan_mode_type             plan_mode = PLAN_FILL;
   int                        plan_run_left = 0;

   int                        sender_idle_pct = 20;
   int                        receiver_idle_pct = 82;
   int                        hold_asked = 0;
   int                        hold_seen = 0;
   int                        hold_left = 0;

   int                        fault_count = 0;
   int                        words_accepted = 0;
   int                        results_checked = 0;
   int                        underflows = 0;
   int                        overflows = 0;
   int                        zero_divisors = 0;
   int                        events_seen = 0;
   int                        deepest = 0;

   forth_data_stack_alu uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // command [3:0], loop_index [35:4], zero [39:36]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // status [1:0], event_value [33:2], stack_depth [40:34]
      .rsp_tuser  (rsp_tuser)    // event_kind [1:0]
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Prints one line per fault, up to a cap, and counts every fault.
   task automatic note_fault(string what);
      fault_count++;
      if (fault_count <= MAX_FAULT_LINES) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Executes one word on the shadow stack and returns what the unit should report.
   // Division is done on magnitudes so that the minimum over minus one wraps cleanly.
   function automatic word_outcome_type run_word(logic [CMD_W-1:0] code,
                                                 logic [DATA_W-1:0] idx);
      word_outcome_type  o;
      int                n;
      int                need;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] q;
      o.status = ST_OK;
      o.kind   = EV_NONE;
      o.value  = '0;
      n        = shadow_depth;
      r        = '0;
      case (code)
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQUAL: need = 2;
         CMD_PRINT, CMD_EMIT, CMD_DUP, CMD_DROP, CMD_INVERT:     need = 1;
         default:                                                need = 0;
      endcase
      if (n < need) begin
         o.status = ST_UNDER;
      end else if ((code == CMD_DUP || code == CMD_INDEX) && n >= STACK_DEPTH) begin
         o.status = ST_OVER;
      end else if (need == 2) begin
         a = shadow_stack[n-2];
         b = shadow_stack[n-1];
         if ((code == CMD_DIV || code == CMD_MOD) && b == '0) begin
            o.status = ST_DIVZ;
         end else begin
            mag_a = a[DATA_W-1] ? -a : a;
            mag_b = b[DATA_W-1] ? -b : b;
            case (code)
               CMD_ADD: r = a + b;
               CMD_SUB: r = a - b;
               CMD_MUL: r = a * b;
               CMD_DIV: begin
                  q = mag_a / mag_b;
                  r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
               end
               CMD_MOD: begin
                  q = mag_a % mag_b;
                  r = a[DATA_W-1] ? -q : q;
               end
               default: r = (a == b) ? FORTH_TRUE : '0;
            endcase
            shadow_stack[n-2] = r;
            n--;
         end
      end else begin
         case (code)
            CMD_PRINT: begin
               o.kind  = EV_PRINT;
               o.value = shadow_stack[n-1];
               n--;
            end
            CMD_EMIT: begin
               o.kind  = EV_EMIT;
               o.value = {24'd0, shadow_stack[n-1][7:0]};
               n--;
            end
            CMD_DUP: begin
               shadow_stack[n] = shadow_stack[n-1];
               n++;
            end
            CMD_DROP:   n--;
            CMD_CR:     o.kind = EV_NEWLINE;
            CMD_INDEX: begin
               shadow_stack[n] = idx;
               n++;
            end
            CMD_INVERT: shadow_stack[n-1] = (shadow_stack[n-1] == '0) ? FORTH_TRUE : '0;
            default: ;
         endcase
      end
      shadow_depth = n;
      o.depth = DEPTH_FIELD_W'(n);
      return o;
   endfunction

   // Queues a word for the driver and keeps the planner's depth estimate roughly in step.
   task automatic queue_word(logic [CMD_W-1:0] code, logic [DATA_W-1:0] idx);
      forth_word_type w;
      w.code = code;
      w.idx  = idx;
      words_to_send.insert(words_to_send.size(), w);
      case (code)
         CMD_DUP, CMD_INDEX: begin
            if (planned_depth < STACK_DEPTH) planned_depth++;
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQUAL: begin
            if (planned_depth >= 2) planned_depth--;
         end
         CMD_PRINT, CMD_EMIT, CMD_DROP: begin
            if (planned_depth >= 1) planned_depth--;
         end
         default: ;
      endcase
   endtask

   // Loop index values: some extremes, many small signed values so that divisors of
   // zero and equal operands turn up often, and the rest fully random.
   function automatic logic [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return FORTH_TRUE;
            default: return '0;
         endcase
      end else if (roll < 50) begin
         return DATA_W'($urandom_range(0, 16)) - 32'd8;
      end
      return $urandom;
   endfunction

   task automatic plan_random_word();
      int               roll;
      logic [CMD_W-1:0] code;
      if (plan_run_left == 0) begin
         plan_mode = (planned_depth < 16) ? PLAN_FILL
                     : plan_mode_type'($urandom_range(PLAN_FILL, PLAN_MIX));
         plan_run_left = $urandom_range(30, 120);
      end
      plan_run_left--;
      roll = $urandom_range(0, 99);
      case (plan_mode)
         PLAN_FILL: begin
            if (roll < 60)      code = CMD_INDEX;
            else if (roll < 85) code = CMD_DUP;
            else                code = CMD_W'($urandom_range(CMD_ADD, CMD_SPARE_LAST));
         end
         PLAN_DRAIN: begin
            if (roll < 25)      code = CMD_DROP;
            else if (roll < 40) code = CMD_PRINT;
            else if (roll < 50) code = CMD_EMIT;
            else if (roll < 78) code = CMD_W'($urandom_range(CMD_ADD, CMD_MOD));
            else if (roll < 85) code = CMD_EQUAL;
            else                code = CMD_W'($urandom_range(CMD_ADD, CMD_SPARE_LAST));
         end
         default: begin
            if (roll < 15) code = CMD_INDEX;
            else           code = CMD_W'($urandom_range(CMD_ADD, CMD_SPARE_LAST));
         end
      endcase
      queue_word(code, pick_value());
   endtask

   // Driver: a new item is offered at the falling edge once the previous one has been
   // taken. A valid item is held, unchanged, until the unit accepts it.
   always @(negedge clock) begin : drive_words
      forth_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (words_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            w = words_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, w.idx, w.code};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off that is counted here so
   // that the unit fills up and stalls its input while the driver keeps offering.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen  <= hold_asked;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: at each rising edge a delivered result is checked against the oldest
   // prediction first, and then any word accepted at this edge is predicted.
   always @(posedge clock) begin : watch_words
      word_outcome_type want;
      word_outcome_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.value  = rsp_tdata[33:2];
            got.depth  = rsp_tdata[40:34];
            got.kind   = event_type'(rsp_tuser);
            if (word_outcomes.size() == 0) begin
               note_fault($sformatf("result with no word outstanding: status %0d depth %0d",
                                    got.status, got.depth));
            end else begin
               want = word_outcomes.pop_front();
               if (got.status !== want.status)
                  note_fault($sformatf("result %0d: status %0d, predicted %0d",
                                       results_checked, got.status, want.status));
               if (got.kind !== want.kind)
                  note_fault($sformatf("result %0d: event kind %0d, predicted %0d",
                                       results_checked, got.kind, want.kind));
               if (got.value !== want.value)
                  note_fault($sformatf("result %0d: event value %h, predicted %h",
                                       results_checked, got.value, want.value));
               if (got.depth !== want.depth)
                  note_fault($sformatf("result %0d: stack depth %0d, predicted %0d",
                                       results_checked, got.depth, want.depth));
               case (want.status)
                  ST_UNDER: underflows++;
                  ST_OVER:  overflows++;
                  ST_DIVZ:  zero_divisors++;
                  default: ;
               endcase
               if (want.kind != EV_NONE) events_seen++;
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            word_outcomes.insert(word_outcomes.size(),
                                 run_word(req_tdata[3:0], req_tdata[35:4]));
            words_accepted++;
            if (shadow_depth > deepest) deepest = shadow_depth;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int k;

      // Directed opening: words on an empty stack, a spare code, the minimum divided by
      // minus one for both divide and modulo, zero divisors, equal both ways, invert
      // both ways, wrapping add and multiply, emit of a wide value, subtract and print.
      queue_word(CMD_ADD, '0);
      queue_word(CMD_DROP, '0);
      queue_word(CMD_CR, '0);
      queue_word(CMD_SPARE_LAST, FORTH_TRUE);
      queue_word(CMD_INDEX, INT_MIN);
      queue_word(CMD_INDEX, FORTH_TRUE);
      queue_word(CMD_DIV, '0);
      queue_word(CMD_INDEX, INT_MIN);
      queue_word(CMD_INDEX, FORTH_TRUE);
      queue_word(CMD_MOD, '0);
      queue_word(CMD_DIV, '0);
      queue_word(CMD_MOD, '0);
      queue_word(CMD_EQUAL, '0);
      queue_word(CMD_INVERT, '0);
      queue_word(CMD_INVERT, '0);
      queue_word(CMD_DUP, '0);
      queue_word(CMD_EQUAL, '0);
      queue_word(CMD_INDEX, INT_MAX);
      queue_word(CMD_ADD, '0);
      queue_word(CMD_DUP, '0);
      queue_word(CMD_MUL, '0);
      queue_word(CMD_INDEX, 32'h0001_2345);
      queue_word(CMD_EMIT, '0);
      queue_word(CMD_INDEX, 32'd9);
      queue_word(CMD_SUB, '0);
      queue_word(CMD_PRINT, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Three phases of random words: a slow receiver, then a slow sender, then both
      // running flat out, the last starting with the long hold-off on the result side.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 20;
               receiver_idle_pct = 82;
            end
            1: begin
               sender_idle_pct   = 82;
               receiver_idle_pct = 20;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               hold_asked++;
            end
         endcase
         plan_run_left = 0;
         for (k = 0; k < ITEMS_PER_PHASE; k++) plan_random_word();
         while (words_to_send.size() != 0) @(posedge clock);
      end

      // The last word may still be on offer, so wait for it to be taken as well.
      while (word_outcomes.size() != 0 || req_tvalid) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d words and checked %0d results; %0d output events, deepest stack %0d.",
               words_accepted, results_checked, events_seen, deepest);
      $display("Failures exercised: %0d underflow, %0d overflow, %0d zero divisor.",
               underflows, overflows, zero_divisors);
      if (fault_count == 0) begin
         $display("forth_data_stack_alu_tb: clean");
      end else begin
         $display("forth_data_stack_alu_tb: errors");
      end
      $finish;
   end

   // Guards against a hung handshake; far longer than the slowest correct run.
   initial begin
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("forth_data_stack_alu_tb: errors");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/fdsa_pkg.sv
hw/rtl/fdsa_div.sv
hw/rtl/fdsa_datapath.sv
hw/rtl/fdsa_ctrl.sv
hw/rtl/forth_data_stack_alu.sv
tb/sv/forth_data_stack_alu_tb.sv
